// File: hdl/gfpe_pkg.sv
// ----------------------------------------------------------------------------
// gfpe_pkg
// Shared types, field widths and GF(2^8) arithmetic for the erasure parity
// encoder.
// ----------------------------------------------------------------------------
package gfpe_pkg;

   localparam int DS_W       = 5;
   localparam int PS_W       = 3;
   localparam int SHARD_W    = 4;
   localparam int ROW_W      = 2;
   localparam int OFFSET_W   = 12;
   localparam int BYTE_W     = 8;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_W      = 5;

   localparam logic [8:0] GF_POLY = 9'h11D;

   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_DATA = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_DATA_SHARDS   = 1'b0,
      CSR_PARITY_SHARDS = 1'b1
   } csr_index_type;

   function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] x;
      logic [BYTE_W-1:0] acc;
      x   = a;
      acc = '0;
      for (int k = 0; k < BYTE_W; k++) begin
         if (b[k]) begin
            acc = acc ^ x;
         end
         x = {x[BYTE_W-2:0], 1'b0} ^ (x[BYTE_W-1] ? GF_POLY[BYTE_W-1:0] : '0);
      end
      return acc;
   endfunction

endpackage

// File: hdl/gfpe_ram.sv
// ----------------------------------------------------------------------------
// gfpe_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module gfpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/gf256_erasure_parity_encoder_core.sv
// A data byte is registered in stage s1 at its transfer; a last-shard byte then
// loads the output group, which emits its parity rows in order, one row per cycle
// while rsp_tready is high. Throughput: one item per cycle while req_tready is high,
// set by the read-modify-write of the parity memory banks (read at transfer, write
// from s1, with forwarding); a last-shard item holds the output for all active rows.
// Reset: synchronous; clears control state and coefficient valid bits, not parity memory.
// ----------------------------------------------------------------------------
// gf256_erasure_parity_encoder_core
// GF(2^8) erasure-code parity encoder: per-row coefficient and parity memory
// banks, multiply-accumulate per data byte, parity rows emitted on last shard.
// ----------------------------------------------------------------------------
module gf256_erasure_parity_encoder_core
   import gfpe_pkg::*;
#(
   parameter int MAX_DATA_SHARDS   = 16,
   parameter int MAX_PARITY_SHARDS = 4,
   parameter int SHARD_BYTES       = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // data_shard[3:0], parity_row[5:4], offset[17:6], value[25:18], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_row[1:0], out_offset[13:2], parity_byte[21:14], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [0:0]            csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int CoefAw    = (MAX_DATA_SHARDS > 1) ? $clog2(MAX_DATA_SHARDS) : 1;
   localparam int CoefSlots = 1 << CoefAw;
   localparam int OffAw     = (SHARD_BYTES > 1) ? $clog2(SHARD_BYTES) : 1;

   logic [DS_W-1:0]     data_shards_ff;
   logic [PS_W-1:0]     parity_shards_ff;
   logic [7:0]          nd;
   logic [PS_W-1:0]     np;

   logic [SHARD_W-1:0]  req_shard;
   logic [ROW_W-1:0]    req_row;
   logic [OFFSET_W-1:0] req_offset;
   logic [BYTE_W-1:0]   req_value;
   logic                in_xfer;
   logic                load_ok;
   logic                data_ok;

   logic                s1_valid_ff;
   logic                s1_emit_ff;
   logic                s1_shard0_ff;
   logic [OFFSET_W-1:0] s1_off_ff;
   logic [BYTE_W-1:0]   s1_value_ff;
   logic                s1_go;
   logic                s1_wr;

   logic                fw_valid_ff;
   logic [OFFSET_W-1:0] fw_off_ff;
   logic                fw_hit;

   logic                grp_valid_ff;
   logic [PS_W-1:0]     grp_idx_ff;
   logic [OFFSET_W-1:0] grp_off_ff;
   logic                grp_last;
   logic                grp_free;
   logic [BYTE_W-1:0]   byte_sel;

   logic [CoefSlots-1:0] cv_ff       [MAX_PARITY_SHARDS];
   logic                 s1_cv_ff    [MAX_PARITY_SHARDS];
   logic [BYTE_W-1:0]    coef_rd     [MAX_PARITY_SHARDS];
   logic [BYTE_W-1:0]    par_rd      [MAX_PARITY_SHARDS];
   logic [BYTE_W-1:0]    new_par     [MAX_PARITY_SHARDS];
   logic [BYTE_W-1:0]    fw_data_ff  [MAX_PARITY_SHARDS];
   logic [BYTE_W-1:0]    grp_bytes_ff[MAX_PARITY_SHARDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         data_shards_ff   <= DS_W'(1);
         parity_shards_ff <= PS_W'(1);
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_DATA_SHARDS:   data_shards_ff   <= csr_wdata;
            CSR_PARITY_SHARDS: parity_shards_ff <= csr_wdata[PS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      nd = {3'b000, data_shards_ff};
      if (data_shards_ff == '0) begin
         nd = 8'd1;
      end else if (nd > 8'(MAX_DATA_SHARDS)) begin
         nd = 8'(MAX_DATA_SHARDS);
      end
      np = parity_shards_ff;
      if (parity_shards_ff == '0) begin
         np = PS_W'(1);
      end else if ({2'b00, parity_shards_ff} > 5'(MAX_PARITY_SHARDS)) begin
         np = PS_W'(MAX_PARITY_SHARDS);
      end
   end

   assign req_shard  = req_tdata[3:0];
   assign req_row    = req_tdata[5:4];
   assign req_offset = req_tdata[17:6];
   assign req_value  = req_tdata[25:18];

   assign in_xfer = req_tvalid && req_tready;
   assign load_ok = in_xfer && (op_type'(req_tuser) == OP_LOAD)
                    && (8'(req_shard) < 8'(MAX_DATA_SHARDS))
                    && (8'(req_row) < 8'(MAX_PARITY_SHARDS));
   assign data_ok = in_xfer && (op_type'(req_tuser) == OP_DATA)
                    && (8'(req_shard) < nd)
                    && ({5'b00000, req_offset} < 17'(SHARD_BYTES));

   assign grp_last   = (grp_idx_ff == (np - PS_W'(1)));
   assign grp_free   = !grp_valid_ff || (rsp_tready && grp_last);
   assign s1_go      = !s1_valid_ff || !s1_emit_ff || grp_free;
   assign s1_wr      = s1_valid_ff && s1_go;
   assign req_tready = s1_go;
   assign fw_hit     = fw_valid_ff && (fw_off_ff == s1_off_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_go) begin
         s1_valid_ff <= data_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (data_ok) begin
         s1_off_ff    <= req_offset;
         s1_value_ff  <= req_value;
         s1_shard0_ff <= (req_shard == '0);
         s1_emit_ff   <= (8'(req_shard) == (nd - 8'd1));
      end
   end

   // drop the forwarding record on a register write with no parity write: inactive rows were not stored
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_valid_ff <= 1'b0;
      end else if (s1_wr) begin
         fw_valid_ff <= 1'b1;
      end else if (csr_we) begin
         fw_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_wr) begin
         fw_off_ff <= s1_off_ff;
      end
      if (s1_wr && s1_emit_ff) begin
         grp_off_ff <= s1_off_ff;
      end
   end

   for (genvar p = 0; p < MAX_PARITY_SHARDS; p++) begin : g_bank
      logic              coef_we;
      logic              par_we;
      logic [BYTE_W-1:0] coef;
      logic [BYTE_W-1:0] prod;
      logic [BYTE_W-1:0] old_par;

      assign coef_we = load_ok && ({3'b000, req_row} == 5'(p));
      assign par_we  = s1_wr && (5'(p) < {2'b00, np});

      gfpe_ram #(
         .WIDTH(BYTE_W),
         .DEPTH(MAX_DATA_SHARDS)
      ) u_coef_ram (
         .clock(clock),
         .we   (coef_we),
         .waddr(CoefAw'(req_shard)),
         .wdata(req_value),
         .re   (data_ok),
         .raddr(CoefAw'(req_shard)),
         .rdata(coef_rd[p])
      );

      gfpe_ram #(
         .WIDTH(BYTE_W),
         .DEPTH(SHARD_BYTES)
      ) u_parity_ram (
         .clock(clock),
         .we   (par_we),
         .waddr(OffAw'(s1_off_ff)),
         .wdata(new_par[p]),
         .re   (data_ok),
         .raddr(OffAw'(req_offset)),
         .rdata(par_rd[p])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[p] <= '0;
         end else if (coef_we) begin
            cv_ff[p][CoefAw'(req_shard)] <= 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (data_ok) begin
            s1_cv_ff[p] <= cv_ff[p][CoefAw'(req_shard)];
         end
         if (s1_wr) begin
            fw_data_ff[p] <= new_par[p];
         end
         if (s1_wr && s1_emit_ff) begin
            grp_bytes_ff[p] <= new_par[p];
         end
      end

      assign coef       = s1_cv_ff[p] ? coef_rd[p] : '0;
      assign prod       = gf_mul(coef, s1_value_ff);
      assign old_par    = fw_hit ? fw_data_ff[p] : par_rd[p];
      assign new_par[p] = s1_shard0_ff ? prod : (old_par ^ prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         grp_idx_ff   <= '0;
      end else if (s1_wr && s1_emit_ff) begin
         grp_valid_ff <= 1'b1;
         grp_idx_ff   <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (grp_last) begin
            grp_valid_ff <= 1'b0;
         end else begin
            grp_idx_ff <= grp_idx_ff + PS_W'(1);
         end
      end
   end

   always_comb begin
      byte_sel = '0;
      for (int p = 0; p < MAX_PARITY_SHARDS; p++) begin
         if ({2'b00, grp_idx_ff} == 5'(p)) begin
            byte_sel = grp_bytes_ff[p];
         end
      end
   end

   assign rsp_tvalid = grp_valid_ff;
   assign rsp_tlast  = grp_last;
   assign rsp_tdata  = {2'b00, byte_sel, grp_off_ff, grp_idx_ff[ROW_W-1:0]};

`ifndef NO_ASSERTIONS
   a_grp_idx_range: assert property (@(posedge clock) disable iff (reset)
      grp_valid_ff |-> (grp_idx_ff < np))
      else $error("output row index beyond active parity rows");

   a_emit_loads_grp: assert property (@(posedge clock) disable iff (reset)
      (s1_wr && s1_emit_ff) |=> (grp_valid_ff && (grp_idx_ff == '0)
                                 && (grp_off_ff == $past(s1_off_ff))))
      else $error("finished offset not loaded into output group");

   a_fw_tracks_write: assert property (@(posedge clock) disable iff (reset)
      s1_wr |=> (fw_valid_ff && (fw_off_ff == $past(s1_off_ff))))
      else $error("forwarding record does not follow parity write");

   a_group_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("parity group dropped before last row");
`endif

endmodule

// File: bench/tb_gf256_erasure_parity_encoder_core.sv
// ----------------------------------------------------------------------------
// tb_gf256_erasure_parity_encoder_core
// Self-checking bench for the GF(2^8) erasure parity encoder. Coefficient
// loads and data bytes are streamed in; a local copy of the coefficient and
// parity banks predicts every emitted parity byte, which is checked in order.
// Directed items cover reset state, saturated register settings and inactive
// rows. Random phases send shard sequences under sender gaps, receiver
// stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_gf256_erasure_parity_encoder_core;
   import gfpe_pkg::*;

   localparam int ROWS          = 4;
   localparam int COLUMNS       = 16;
   localparam int SHARD_LEN     = 4096;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 100000;

   typedef struct packed {
      logic [ROW_W-1:0]    row;
      logic [OFFSET_W-1:0] offs;
      logic [BYTE_W-1:0]   pbyte;
      logic                last;
   } parity_byte_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we      = 1'b0;
   logic [0:0]            csr_addr    = '0;
   logic [CSR_W-1:0]      csr_wdata   = '0;

   logic [BYTE_W-1:0] coef_bank      [ROWS][COLUMNS];
   logic [BYTE_W-1:0] parity_bank    [ROWS][SHARD_LEN];
   bit                parity_written [ROWS][SHARD_LEN];
   logic [DS_W-1:0]   set_data_shards   = 5'd1;
   logic [PS_W-1:0]   set_parity_shards = 3'd1;
   parity_byte_type   parity_due[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int hold_left      = 0;
   int cycle_count    = 0;
   int input_stalls   = 0;
   int items_sent     = 0;
   int items_live     = 0;
   int loads_sent     = 0;
   int bytes_checked  = 0;
   int fail_count     = 0;

   parity_byte_type want;
   parity_byte_type got;

   gf256_erasure_parity_encoder_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [BYTE_W-1:0] gf_times(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] x;
      acc = '0;
      x   = a;
      for (int k = 0; k < BYTE_W; k++) begin
         if (b[k]) begin
            acc = acc ^ x;
         end
         x = x[BYTE_W-1] ? ((x << 1) ^ GF_POLY[BYTE_W-1:0]) : (x << 1);
      end
      return acc;
   endfunction

   function automatic int active_shards();
      if (set_data_shards == 0) return 1;
      if (set_data_shards > COLUMNS) return COLUMNS;
      return int'(set_data_shards);
   endfunction

   function automatic int active_rows();
      if (set_parity_shards == 0) return 1;
      if (set_parity_shards > ROWS) return ROWS;
      return int'(set_parity_shards);
   endfunction

   function automatic bit offset_seeded(input logic [OFFSET_W-1:0] offs);
      for (int p = 0; p < active_rows(); p++) begin
         if (!parity_written[p][offs]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   // advance the local banks by one accepted transfer and queue parity due
   task automatic encode_item(input op_type op, input logic [SHARD_W-1:0] shard,
                              input logic [ROW_W-1:0] row,
                              input logic [OFFSET_W-1:0] offs,
                              input logic [BYTE_W-1:0] val);
      int nd;
      int np;
      logic [BYTE_W-1:0] prod;
      parity_byte_type r;
      if (op == OP_LOAD) begin
         coef_bank[row][shard] = val;
         loads_sent++;
         items_live++;
         return;
      end
      nd = active_shards();
      np = active_rows();
      if (shard >= nd) return;
      items_live++;
      for (int p = 0; p < np; p++) begin
         prod = gf_times(coef_bank[p][shard], val);
         if (shard == 0) begin
            parity_bank[p][offs]    = prod;
            parity_written[p][offs] = 1'b1;
         end else begin
            parity_bank[p][offs] = parity_bank[p][offs] ^ prod;
         end
      end
      if (shard != nd - 1) return;
      for (int p = 0; p < np; p++) begin
         r.row   = ROW_W'(p);
         r.offs  = offs;
         r.pbyte = parity_bank[p][offs];
         r.last  = (p == np - 1);
         parity_due.push_back(r);
      end
   endtask

   task automatic send_item(input op_type op, input logic [SHARD_W-1:0] shard,
                            input logic [ROW_W-1:0] row,
                            input logic [OFFSET_W-1:0] offs,
                            input logic [BYTE_W-1:0] val);
      logic [SHARD_W-1:0] s;
      s = shard;
      // a later shard may only land on an offset that shard 0 has seeded
      if (op == OP_DATA && s != 0 && s < active_shards() && !offset_seeded(offs)) begin
         s = '0;
      end
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, val, offs, row, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      encode_item(op, s, row, offs, val);
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (parity_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DATA_SHARDS) begin
         set_data_shards = val;
      end else begin
         set_parity_shards = val[PS_W-1:0];
      end
   endtask

   task automatic set_geometry(input logic [CSR_W-1:0] ds, input logic [CSR_W-1:0] ps);
      settle();
      write_csr(CSR_DATA_SHARDS, ds);
      write_csr(CSR_PARITY_SHARDS, ps);
   endtask

   task automatic test_reset_state();
      // zero coefficients give zero parity; shard beyond count is dropped
      send_item(OP_DATA, 4'd0, 2'd3, 12'd0, 8'hFF);
      send_item(OP_DATA, 4'd5, 2'd0, 12'hFFF, 8'h5A);
   endtask

   task automatic test_coefficient_loads();
      send_item(OP_LOAD, 4'd0, 2'd0, 12'hFFF, 8'h01);
      send_item(OP_LOAD, 4'd0, 2'd1, 12'h000, 8'hFF);
      send_item(OP_LOAD, 4'd0, 2'd2, 12'hA5A, 8'h80);
      send_item(OP_LOAD, 4'd0, 2'd3, 12'h5A5, 8'h02);
      send_item(OP_LOAD, 4'd15, 2'd3, 12'hFFF, 8'hFF);
      send_item(OP_LOAD, 4'd1, 2'd0, 12'h000, 8'h1D);
      // only row 0 is active here
      send_item(OP_DATA, 4'd0, 2'd2, 12'd1, 8'hAB);
   endtask

   task automatic test_register_extremes();
      set_geometry(5'd2, 5'd7);
      send_item(OP_DATA, 4'd0, 2'd1, 12'hFFF, 8'hFF);
      send_item(OP_DATA, 4'd1, 2'd2, 12'hFFF, 8'h80);
      send_item(OP_DATA, 4'd2, 2'd0, 12'hFFF, 8'h33);
      set_geometry(5'd31, 5'b11100);
      send_item(OP_DATA, 4'd15, 2'd3, 12'hFFF, 8'hFF);
      set_geometry(5'd0, 5'd0);
      send_item(OP_DATA, 4'd0, 2'd0, 12'd2048, 8'h01);
   endtask

   task automatic test_random_traffic(input int n, input logic [CSR_W-1:0] ds,
                                      input logic [CSR_W-1:0] ps,
                                      input int idle, input int stall);
      int goal;
      int pick;
      int nd;
      int stop_at;
      logic [OFFSET_W-1:0] offs;
      set_geometry(ds, ps);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      goal = items_live + n;
      nd   = active_shards();
      while (items_live < goal) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_item(OP_LOAD, SHARD_W'($urandom), ROW_W'($urandom),
                      OFFSET_W'($urandom), BYTE_W'($urandom));
         end else if (pick < 20) begin
            send_item(OP_DATA, SHARD_W'($urandom), ROW_W'($urandom),
                      OFFSET_W'($urandom), BYTE_W'($urandom));
         end else begin
            offs    = OFFSET_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(63));
            stop_at = ($urandom_range(9) == 0) ? $urandom_range(nd - 1) : nd - 1;
            for (int s = 0; s <= stop_at; s++) begin
               send_item(OP_DATA, SHARD_W'(s), ROW_W'($urandom), offs, BYTE_W'($urandom));
            end
         end
      end
   endtask

   task automatic test_output_holdoff();
      set_geometry(5'd1, 5'd4);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 200;
      for (int i = 0; i < 30; i++) begin
         send_item(OP_DATA, 4'd0, ROW_W'($urandom), OFFSET_W'($urandom), BYTE_W'($urandom));
      end
   endtask

   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.row   = rsp_tdata[1:0];
         got.offs  = rsp_tdata[13:2];
         got.pbyte = rsp_tdata[21:14];
         got.last  = rsp_tlast;
         if (parity_due.size() == 0) begin
            note_failure($sformatf("unexpected parity transfer: row %0d offset %0d byte %02h last %0b",
                                   got.row, got.offs, got.pbyte, got.last));
         end else begin
            want = parity_due.pop_front();
            bytes_checked++;
            if (got !== want) begin
               note_failure($sformatf({"parity mismatch: expected row %0d offset %0d byte %02h ",
                                       "last %0b, got row %0d offset %0d byte %02h last %0b"},
                                      want.row, want.offs, want.pbyte, want.last,
                                      got.row, got.offs, got.pbyte, got.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (req_tvalid && !req_tready) begin
         input_stalls++;
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d parity bytes outstanding",
                  cycle_count, parity_due.size());
         $display("tb_gf256_erasure_parity_encoder_core: FAIL");
         $finish;
      end
   end

   initial begin
      for (int p = 0; p < ROWS; p++) begin
         for (int c = 0; c < COLUMNS; c++) begin
            coef_bank[p][c] = '0;
         end
         for (int o = 0; o < SHARD_LEN; o++) begin
            parity_bank[p][o]    = '0;
            parity_written[p][o] = 1'b0;
         end
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_coefficient_loads();
      test_register_extremes();
      test_random_traffic(48, 5'd16, 5'd4, 0, 0);
      test_random_traffic(48, 5'd3, 5'd2, 76, 0);
      test_random_traffic(48, 5'd1, 5'd4, 0, 76);
      test_random_traffic(48, CSR_W'($urandom_range(31)), CSR_W'($urandom_range(7)), 15, 15);
      test_output_holdoff();

      settle();
      $display("Run covered %0d input transfers (%0d changing state, %0d coefficient loads)",
               items_sent, items_live, loads_sent);
      $display("and %0d parity bytes checked; input held off %0d cycles under back-pressure",
               bytes_checked, input_stalls);
      if (fail_count == 0 && parity_due.size() == 0) begin
         $display("tb_gf256_erasure_parity_encoder_core: PASS");
      end else begin
         $display("tb_gf256_erasure_parity_encoder_core: FAIL");
      end
      $finish;
   end

endmodule
